[hw/rtl/vrc_pkg.sv]
package vrc_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_BAD_IDX = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_VPM       = 3'd0,
    CFG_RANGE     = 3'd1,
    CFG_FREE_THR  = 3'd2,
    CFG_BUSY_THR  = 3'd3,
    CFG_OCC_ONLY  = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [7:0]  CostMax  = 8'd255;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic [5:0]         voxel_row;
    logic [5:0]         voxel_col;
    logic [4:0]         voxel_height;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  cost;
    logic [15:0] visit_count;
    logic [15:0] hit_count;
    logic [1:0]  status;
  } out_item_t;

endpackage

[hw/rtl/voxel_ray_cast_occupancy_unit.sv]
// insert: visits each voxel on the ray (longest axis length + 1), unless occupancy-only mode is set,
//   the visit store doing one read-modify-write per cycle
// read: the 8-step restoring divider runs only when the cost needs it
// clear: all GRID_XY*GRID_XY*GRID_Z entries, one entry of both stores per cycle
// one item at a time; reset clears registers and then runs the same
//   clearing pass, during which no item is accepted
module voxel_ray_cast_occupancy_unit #(
  parameter int unsigned GRID_XY     = 64,
  parameter int unsigned GRID_Z      = 32,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  vrc_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output vrc_pkg::out_item_t         out_item_o,
  input  logic                       cfg_we_i,
  input  logic [vrc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vrc_pkg::CfgDataW-1:0] cfg_data_i
);
  import vrc_pkg::*;

  localparam int unsigned Cells = GRID_XY * GRID_XY * GRID_Z;
  localparam int unsigned AW    = $clog2(Cells);
  localparam int unsigned XW    = $clog2(GRID_XY);
  localparam int unsigned ZW    = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
  localparam int unsigned LW    = ((XW > ZW) ? XW : ZW) + 1;
  localparam int unsigned EW    = LW + 3;
  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int          Half  = GRID_XY / 2;
  localparam int unsigned TW    = 36;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_CLEAR  = 11'b00000000010,
    S_MUL    = 11'b00000000100,
    S_CHK    = 11'b00000001000,
    S_HITRD  = 11'b00000010000,
    S_HITWR  = 11'b00000100000,
    S_WALK   = 11'b00001000000,
    S_DRAIN  = 11'b00010000000,
    S_RDWAIT = 11'b00100000000,
    S_DIV    = 11'b01000000000,
    S_RESP   = 11'b10000000000
  } state_e;

  function automatic logic [AW-1:0] cell_addr(input int x, input int y, input int z);
    int a;
    a = (x * int'(GRID_XY) + y) * int'(GRID_Z) + z;
    return a[AW-1:0];
  endfunction

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  state_e st_q, st_d;

  logic [15:0] vpm_q, range_q, free_q, busy_q;
  logic        occ_q;

  in_item_t  in_q, in_d;
  out_item_t res_q, res_d, out_q;
  logic      out_valid_q, out_valid_d;
  logic      clr_resp_q, clr_resp_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [CW-1:0] max_q, max_d;

  logic [31:0] sqx_q, sqy_q, sqz_q, r2_q;
  logic signed [32:0] prx_q, pry_q, prz_q;

  logic [XW-1:0] ex_q, ey_q, px_q, py_q;
  logic [ZW-1:0] ez_q, pz_q;
  logic [XW-1:0] ex_d, ey_d, px_d, py_d;
  logic [ZW-1:0] ez_d, pz_d;
  logic [2:0]    inc_q, drv_q;
  logic [LW-1:0] lx_q, ly_q, lz_q, la_q, cnt_q, cnt_d;
  logic signed [EW-1:0] erx_q, ery_q, erz_q, erx_d, ery_d, erz_d;

  logic          pend_q, pend_d;
  logic [AW-1:0] pend_a_q, pend_a_d;

  logic [CW-1:0] rem_q, rem_d;
  logic [7:0]    num_q, num_d, quo_q, quo_d;
  logic [2:0]    dcnt_q, dcnt_d;

  logic          hit_we, vis_we;
  logic [AW-1:0] hit_wa, vis_wa, hit_ra, vis_ra;
  logic [CW-1:0] hit_wd, vis_wd, hit_rd, vis_rd;

  vrc_ram #(.Width(CW), .Depth(Cells)) u_hit_ram (
    .clk_i, .we_i(hit_we), .waddr_i(hit_wa), .wdata_i(hit_wd),
    .raddr_i(hit_ra), .rdata_o(hit_rd)
  );

  vrc_ram #(.Width(CW), .Depth(Cells)) u_visit_ram (
    .clk_i, .we_i(vis_we), .waddr_i(vis_wa), .wdata_i(vis_wd),
    .raddr_i(vis_ra), .rdata_o(vis_rd)
  );

  // range check and grid mapping
  logic [33:0] d2;
  logic signed [TW-1:0] tx, ty, tz;
  logic ox, oy, oz;
  assign d2 = {2'b0, sqx_q} + {2'b0, sqy_q} + {2'b0, sqz_q};
  assign tx = TW'(prx_q) + (TW'(Half) <<< 16);
  assign ty = TW'(pry_q) + (TW'(Half) <<< 16);
  assign tz = TW'(prz_q);
  assign ox = tx[TW-1] || (tx[TW-1:16] >= (TW-16)'(GRID_XY));
  assign oy = ty[TW-1] || (ty[TW-1:16] >= (TW-16)'(GRID_XY));
  assign oz = tz[TW-1] || (tz[TW-1:16] >= (TW-16)'(GRID_Z));

  // walk setup from the endpoint
  int dxi, dyi, dzi, lxi, lyi, lzi, lai;
  logic [2:0] drv_s;
  always_comb begin
    dxi = int'(ex_q) - Half;
    dyi = int'(ey_q) - Half;
    dzi = int'(ez_q);
    lxi = (dxi < 0) ? -dxi : dxi;
    lyi = (dyi < 0) ? -dyi : dyi;
    lzi = dzi;
    if (lxi >= lyi && lxi >= lzi) begin
      drv_s = 3'b001;
      lai   = lxi;
    end else if (lyi >= lzi) begin
      drv_s = 3'b010;
      lai   = lyi;
    end else begin
      drv_s = 3'b100;
      lai   = lzi;
    end
  end

  // one bresenham step
  logic signed [EW-1:0] la2, lx2, ly2, lz2;
  assign la2 = EW'(la_q) <<< 1;
  assign lx2 = EW'(lx_q) <<< 1;
  assign ly2 = EW'(ly_q) <<< 1;
  assign lz2 = EW'(lz_q) <<< 1;

  // read path cost
  logic [31:0] v32;
  logic [CW+7:0] num_full;
  assign v32      = 32'(vis_rd);
  assign num_full = ({(CW+8)'(max_q - vis_rd)} << 8) - (CW+8)'(max_q - vis_rd);

  logic [CW:0] rem_sh;
  assign rem_sh = {rem_q, num_q[7]};

  always_comb begin
    st_d        = st_q;
    in_d        = in_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    clr_resp_d  = clr_resp_q;
    clr_d       = clr_q;
    max_d       = max_q;
    ex_d = ex_q; ey_d = ey_q; ez_d = ez_q;
    px_d = px_q; py_d = py_q; pz_d = pz_q;
    erx_d = erx_q; ery_d = ery_q; erz_d = erz_q;
    cnt_d       = cnt_q;
    pend_d      = 1'b0;
    pend_a_d    = pend_a_q;
    rem_d = rem_q; num_d = num_q; quo_d = quo_q; dcnt_d = dcnt_q;
    hit_we = 1'b0; hit_wa = clr_q; hit_wd = '0;
    vis_we = 1'b0; vis_wa = clr_q; vis_wd = '0;
    hit_ra = cell_addr(int'(in_item_i.voxel_row), int'(in_item_i.voxel_col),
                       int'(in_item_i.voxel_height));
    vis_ra = hit_ra;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (pend_q) begin
      vis_we = 1'b1;
      vis_wa = pend_a_q;
      vis_wd = sat_inc(vis_rd);
      if (sat_inc(vis_rd) > max_q) begin
        max_d = sat_inc(vis_rd);
      end
    end

    unique case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_d  = in_item_i;
          res_d = '0;
          unique case (in_item_i.command)
            CMD_CLEAR: begin
              clr_d      = '0;
              max_d      = '0;
              clr_resp_d = 1'b1;
              st_d       = S_CLEAR;
            end
            CMD_INSERT: st_d = S_MUL;
            CMD_READ: begin
              if (int'(in_item_i.voxel_row) >= int'(GRID_XY) ||
                  int'(in_item_i.voxel_col) >= int'(GRID_XY) ||
                  int'(in_item_i.voxel_height) >= int'(GRID_Z)) begin
                res_d.status = ST_BAD_IDX;
                st_d         = S_RESP;
              end else begin
                st_d = S_RDWAIT;
              end
            end
            default: st_d = S_RESP;
          endcase
        end
      end
      S_CLEAR: begin
        hit_we = 1'b1;
        vis_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == AW'(Cells - 1)) begin
          st_d       = clr_resp_q ? S_RESP : S_IDLE;
          clr_resp_d = 1'b0;
        end
      end
      S_MUL: st_d = S_CHK;
      S_CHK: begin
        if (d2 > {2'b0, r2_q}) begin
          res_d.status = ST_RANGE;
          st_d         = S_RESP;
        end else if (ox || oy || oz) begin
          res_d.status = ST_OUTSIDE;
          st_d         = S_RESP;
        end else begin
          ex_d = tx[16 +: XW];
          ey_d = ty[16 +: XW];
          ez_d = tz[16 +: ZW];
          st_d = S_HITRD;
        end
      end
      S_HITRD: begin
        hit_ra = cell_addr(int'(ex_q), int'(ey_q), int'(ez_q));
        st_d   = S_HITWR;
      end
      S_HITWR: begin
        hit_we = 1'b1;
        hit_wa = cell_addr(int'(ex_q), int'(ey_q), int'(ez_q));
        hit_wd = sat_inc(hit_rd);
        px_d   = XW'(Half);
        py_d   = XW'(Half);
        pz_d   = '0;
        cnt_d  = LW'(lai);
        erx_d  = EW'(2 * lxi - lai);
        ery_d  = EW'(2 * lyi - lai);
        erz_d  = EW'(2 * lzi - lai);
        st_d   = occ_q ? S_RESP : S_WALK;
      end
      S_WALK: begin
        vis_ra   = cell_addr(int'(px_q), int'(py_q), int'(pz_q));
        pend_d   = 1'b1;
        pend_a_d = vis_ra;
        if (cnt_q == '0) begin
          st_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
          if (drv_q[0]) begin
            px_d = inc_q[0] ? px_q - 1'b1 : px_q + 1'b1;
          end else if (erx_q > 0) begin
            px_d  = inc_q[0] ? px_q - 1'b1 : px_q + 1'b1;
            erx_d = erx_q - la2 + lx2;
          end else begin
            erx_d = erx_q + lx2;
          end
          if (drv_q[1]) begin
            py_d = inc_q[1] ? py_q - 1'b1 : py_q + 1'b1;
          end else if (ery_q > 0) begin
            py_d  = inc_q[1] ? py_q - 1'b1 : py_q + 1'b1;
            ery_d = ery_q - la2 + ly2;
          end else begin
            ery_d = ery_q + ly2;
          end
          if (drv_q[2]) begin
            pz_d = pz_q + 1'b1;
          end else if (erz_q > 0) begin
            pz_d  = pz_q + 1'b1;
            erz_d = erz_q - la2 + lz2;
          end else begin
            erz_d = erz_q + lz2;
          end
        end
      end
      S_DRAIN: st_d = S_RESP;
      S_RDWAIT: begin
        res_d.visit_count = 16'(vis_rd);
        res_d.hit_count   = 16'(hit_rd);
        st_d              = S_RESP;
        if (hit_rd != '0) begin
          res_d.cost = '0;
        end else if (v32 <= 32'(free_q)) begin
          res_d.cost = CostMax;
        end else if (v32 > 32'(busy_q) || max_q == '0 || vis_rd > max_q) begin
          res_d.cost = '0;
        end else begin
          rem_d  = num_full[CW+7:8];
          num_d  = num_full[7:0];
          dcnt_d = '0;
          st_d   = S_DIV;
        end
      end
      S_DIV: begin
        num_d  = {num_q[6:0], 1'b0};
        dcnt_d = dcnt_q + 1'b1;
        if (rem_sh >= {1'b0, max_q}) begin
          rem_d = CW'(rem_sh - {1'b0, max_q});
          quo_d = {quo_q[6:0], 1'b1};
        end else begin
          rem_d = rem_sh[CW-1:0];
          quo_d = {quo_q[6:0], 1'b0};
        end
        if (dcnt_q == 3'd7) begin
          res_d.cost = {quo_q[6:0], (rem_sh >= {1'b0, max_q})};
          st_d       = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          st_d        = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_CLEAR;
      clr_q       <= '0;
      clr_resp_q  <= 1'b0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      vpm_q       <= 16'd2560;
      range_q     <= 16'd5120;
      free_q      <= 16'd0;
      busy_q      <= 16'd100;
      occ_q       <= 1'b0;
    end else begin
      st_q        <= st_d;
      clr_q       <= clr_d;
      clr_resp_q  <= clr_resp_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_VPM:      vpm_q   <= cfg_data_i;
          CFG_RANGE:    range_q <= cfg_data_i;
          CFG_FREE_THR: free_q  <= cfg_data_i;
          CFG_BUSY_THR: busy_q  <= cfg_data_i;
          CFG_OCC_ONLY: occ_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    in_q     <= in_d;
    res_q    <= res_d;
    pend_a_q <= pend_a_d;
    ex_q <= ex_d; ey_q <= ey_d; ez_q <= ez_d;
    px_q <= px_d; py_q <= py_d; pz_q <= pz_d;
    erx_q <= erx_d; ery_q <= ery_d; erz_q <= erz_d;
    cnt_q <= cnt_d;
    rem_q <= rem_d; num_q <= num_d; quo_q <= quo_d; dcnt_q <= dcnt_d;
    sqx_q <= 32'(in_q.point_x) * 32'(in_q.point_x);
    sqy_q <= 32'(in_q.point_y) * 32'(in_q.point_y);
    sqz_q <= 32'(in_q.point_z) * 32'(in_q.point_z);
    r2_q  <= range_q * range_q;
    prx_q <= in_q.point_x * $signed({1'b0, vpm_q});
    pry_q <= in_q.point_y * $signed({1'b0, vpm_q});
    prz_q <= in_q.point_z * $signed({1'b0, vpm_q});
    if (st_q == S_HITRD) begin
      lx_q  <= LW'(lxi);
      ly_q  <= LW'(lyi);
      lz_q  <= LW'(lzi);
      la_q  <= LW'(lai);
      drv_q <= drv_s;
      inc_q <= {1'b0, (dyi < 0), (dxi < 0)};
    end
    if (st_q == S_RESP && (!out_valid_q || out_ready_i)) begin
      out_q <= res_q;
    end
  end

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> (st_q == S_IDLE && clr_resp_q == 1'b0))
    else $error("item taken outside idle");

  a_pend_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (st_q == S_WALK || st_q == S_DRAIN))
    else $error("visit write outside ray walk");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DIV) |-> (max_q != '0))
    else $error("divider running with zero maximum");

  a_max_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (max_q < $past(max_q)) |-> ($past(st_q) == S_IDLE || $past(st_q) == S_CLEAR))
    else $error("visit maximum dropped without clear");

  a_resp_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_RESP && out_valid_q && !out_ready_i) |=> (st_q == S_RESP))
    else $error("result dropped while output busy");

endmodule

[hw/rtl/vrc_ram.sv]
module vrc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
